/* rtl/rrdt_pkg.sv */
// Shared types, constants and codes of the resample ratio delay tracker.
// No dependencies; every other file in rtl imports this package.
package rrdt_pkg;

	localparam int MAX_PERIOD      = 8192;
	localparam int RATIO_FRAC_BITS = 28;

	localparam int DELAY_W  = 16;
	localparam int PERIOD_W = 14;
	localparam int TGT_W    = 15;
	localparam int CUB_W    = 20;
	localparam int LIN_W    = 27;
	localparam int RATIO_W  = 31;
	localparam int CFG_W    = 31;
	localparam int IDX_W    = 3;
	localparam int OFF_W    = 18;
	localparam int DEN_W    = PERIOD_W + LIN_W;
	localparam int DIV_W    = 64;
	localparam int CNT_W    = 7;
	localparam int Q_W      = 28;
	localparam int SQ_W     = 36;
	localparam int T1_W     = DIV_W - (40 - RATIO_FRAC_BITS);
	localparam int T2_W     = 16 + RATIO_FRAC_BITS;
	localparam int MAG_W    = 32;
	localparam int RS_W     = 34;
	localparam int PROD_W   = PERIOD_W + RATIO_W;

	// Iteration counts of the divider for each quotient.
	localparam logic [CNT_W-1:0] ITER_Q = CNT_W'(16 + 20);
	localparam logic [CNT_W-1:0] ITER_C = CNT_W'(DIV_W);
	localparam logic [CNT_W-1:0] ITER_L = CNT_W'(16 + RATIO_FRAC_BITS);

	localparam logic [MAG_W-1:0]   RATIO_LIM = MAG_W'(64'd8 << RATIO_FRAC_BITS);
	localparam logic [RATIO_W-1:0] RATIO_MIN = RATIO_W'(64'd1 << (RATIO_FRAC_BITS - 2));
	localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(64'd4 << RATIO_FRAC_BITS);
	localparam logic [RS_W-1:0]    DAMP_EPS  = RS_W'((64'd1 << RATIO_FRAC_BITS) / 10000);
	localparam logic [PROD_W-1:0]  ROUND_UP  = PROD_W'((64'd1 << RATIO_FRAC_BITS) - 1);

	localparam logic [TGT_W-1:0]   RST_TARGET  = TGT_W'(1024);
	localparam logic [TGT_W-1:0]   RST_MAXDIFF = TGT_W'(512);
	localparam logic [CUB_W-1:0]   RST_CUBIC   = CUB_W'(1000);
	localparam logic [LIN_W-1:0]   RST_LINEAR  = LIN_W'(1000000);
	localparam logic [RATIO_W-1:0] RST_NOMINAL = RATIO_W'(268435456);

	typedef enum logic [IDX_W-1:0] {
		REG_TARGET  = 3'd0,
		REG_MAXDIFF = 3'd1,
		REG_CUBIC   = 3'd2,
		REG_LINEAR  = 3'd3,
		REG_NOMINAL = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_REWIND = 2'd1,
		ACT_PAD    = 2'd2
	} skip_act_t;

	typedef enum logic [1:0] {
		DIV_Q = 2'd0,
		DIV_C = 2'd1,
		DIV_L = 2'd2
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVQ,
		ST_WAITQ,
		ST_SQ,
		ST_MLO,
		ST_MHI,
		ST_DIVC,
		ST_WAITC,
		ST_DIVL,
		ST_WAITL,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic     load;
		logic     div_go;
		logic     div_take;
		div_sel_t div_sel;
		logic     sq;
		logic     mlo;
		logic     mhi;
		logic     fin;
		logic     emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic huge;
		logic out_full;
	} ctl_stat_t;

endpackage

/* rtl/rrdt_if.sv */
// Handshake channel interfaces for the input and result items of the tracker.
// Depends on rrdt_pkg for field widths.
interface rrdt_in_if import rrdt_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [DELAY_W-1:0]  measured_delay;
	logic        [PERIOD_W-1:0] period_frames;

	modport source (output valid, measured_delay, period_frames, input ready);
	modport sink   (input valid, measured_delay, period_frames, output ready);
endinterface

interface rrdt_out_if import rrdt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic        [1:0]         skip_action;
	logic        [15:0]        skip_frames;
	logic        [RATIO_W-1:0] ratio_out;
	logic signed [15:0]        delay_offset;
	logic        [15:0]        request_frames;

	modport source (output valid, skip_action, skip_frames, ratio_out, delay_offset,
		request_frames, input ready);
	modport sink   (input valid, skip_action, skip_frames, ratio_out, delay_offset,
		request_frames, output ready);
endinterface

/* rtl/resample_ratio_delay_tracker_core.sv */
// Top level of the resample ratio delay tracker.
// Depends on rrdt_pkg, rrdt_if, rrdt_ctrl and rrdt_dp.

// One input item per audio period carries the measured device delay and the
// period length; one result item comes back for each, with the skip action and
// its frame count, the new Q3.28 resampling ratio, the delay offset and the
// number of source frames to request. The single shared divider produces one
// quotient bit per cycle for three quotients in turn (36, 64 and 44 bits);
// when the correction saturates, only the first is computed. The block works
// on one item at a time and takes the next one once the previous result has
// been written to the output register, and a result may still be waiting
// there while the next item is accepted. The user must write the configuration
// registers through a plain write port only while the block is idle; the block
// itself does not enforce this. A new nominal ratio takes effect at the next
// rewind, pad or damping step.
module resample_ratio_delay_tracker_core import rrdt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	rrdt_in_if.sink          in_ch,
	rrdt_out_if.source       out_ch
);

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	// The controller only sequences; all arithmetic and data state sit in the datapath.
	rrdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rrdt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.stat        (stat),
		.in_delay    (in_ch.measured_delay),
		.in_period   (in_ch.period_frames),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.out_action  (out_ch.skip_action),
		.out_frames  (out_ch.skip_frames),
		.out_ratio   (out_ch.ratio_out),
		.out_offset  (out_ch.delay_offset),
		.out_request (out_ch.request_frames)
	);

	// An accepted item occupies the block, so no second item follows at once.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("second item accepted while one is in progress");

	// Every delivered ratio lies inside the clamp range.
	a_ratio_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.ratio_out >= RATIO_MIN && out_ch.ratio_out <= RATIO_MAX))
		else $error("ratio outside clamp range");

	// No skip action means no frames to skip.
	a_no_action_no_frames: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.skip_action == ACT_NONE |-> out_ch.skip_frames == 16'd0)
		else $error("frames reported without a skip action");

	// A correction is never reported alongside a non-zero offset.
	a_skip_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.skip_action != ACT_NONE |-> out_ch.delay_offset == 16'sd0)
		else $error("offset left after rewind or pad");

endmodule

/* rtl/rrdt_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all quotients.
// Depends on rrdt_pkg for widths.
module rrdt_div import rrdt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	input  logic [CNT_W-1:0] iters,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? DEN_W'(trial - {1'b0, dvs_q}) : trial[DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/rrdt_dp.sv */
// Datapath of the tracker: configuration registers, loop state, correction
// arithmetic and the result register. Depends on rrdt_pkg and rrdt_div.
module rrdt_dp import rrdt_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic        [IDX_W-1:0]    cfg_index,
	input  logic        [CFG_W-1:0]    cfg_data,
	input  ctl_cmd_t                   cmd,
	output ctl_stat_t                  stat,
	input  logic signed [DELAY_W-1:0]  in_delay,
	input  logic        [PERIOD_W-1:0] in_period,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic        [1:0]          out_action,
	output logic        [15:0]         out_frames,
	output logic        [RATIO_W-1:0]  out_ratio,
	output logic signed [15:0]         out_offset,
	output logic        [15:0]         out_request
);

	// configuration
	logic [TGT_W-1:0]   tgt_q, md_q;
	logic [CUB_W-1:0]   cub_q;
	logic [LIN_W-1:0]   lin_q;
	logic [RATIO_W-1:0] nom_q;

	// loop state
	logic [RATIO_W-1:0] ratio_q;
	logic               win_q;

	// per item working registers
	logic [PERIOD_W-1:0]     n_q;
	logic signed [OFF_W-1:0] off_q;
	logic [15:0]             u_q;
	skip_act_t               act_q;
	logic [15:0]             frm_q;
	logic [RATIO_W-1:0]      r_q;
	logic [DEN_W-1:0]        den_q;
	logic [Q_W-1:0]          qv_q;
	logic                    huge_q;
	logic [SQ_W-1:0]         sq_q;
	logic [DIV_W-1:0]        cube_q;
	logic [T1_W-1:0]         t1_q;
	logic [T2_W-1:0]         t2_q;

	logic                 out_valid_q;
	skip_act_t            oact_q;
	logic [15:0]          ofrm_q, ooff_q, oreq_q;
	logic [RATIO_W-1:0]   orat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q <= RST_TARGET;
			md_q  <= RST_MAXDIFF;
			cub_q <= RST_CUBIC;
			lin_q <= RST_LINEAR;
			nom_q <= RST_NOMINAL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET:  tgt_q <= cfg_data[TGT_W-1:0];
				REG_MAXDIFF: md_q  <= cfg_data[TGT_W-1:0];
				REG_CUBIC:   cub_q <= cfg_data[CUB_W-1:0];
				REG_LINEAR:  lin_q <= cfg_data[LIN_W-1:0];
				REG_NOMINAL: nom_q <= cfg_data[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	// Item load: threshold test, corrected offset and the linear denominator.
	logic signed [OFF_W-1:0] dly_s, tgt_s, hi_s, lo_s, dcor_s, off_s, frm_s;
	logic [PERIOD_W-1:0]     n_c;
	logic [LIN_W-1:0]        lin_e;
	skip_act_t               act_c;

	always_comb begin
		dly_s  = {{(OFF_W-DELAY_W){in_delay[DELAY_W-1]}}, in_delay};
		tgt_s  = $signed({{(OFF_W-TGT_W){1'b0}}, tgt_q});
		hi_s   = tgt_s + $signed({{(OFF_W-TGT_W){1'b0}}, md_q});
		lo_s   = tgt_s - $signed({{(OFF_W-TGT_W){1'b0}}, md_q});
		act_c  = ACT_NONE;
		frm_s  = '0;
		dcor_s = dly_s;
		if (dly_s > hi_s) begin
			act_c  = ACT_REWIND;
			frm_s  = dly_s - tgt_s;
			dcor_s = tgt_s;
		end else if (dly_s < lo_s) begin
			act_c  = ACT_PAD;
			frm_s  = tgt_s - dly_s;
			dcor_s = tgt_s;
		end
		off_s = dcor_s - tgt_s;
		if (in_period == '0) begin
			n_c = PERIOD_W'(1);
		end else if (in_period > PERIOD_W'(MAX_PERIOD)) begin
			n_c = PERIOD_W'(MAX_PERIOD);
		end else begin
			n_c = in_period;
		end
		lin_e = (lin_q == '0) ? LIN_W'(1) : lin_q;
	end

	// Divider operands.
	logic [DIV_W-1:0] div_dividend, div_quo;
	logic [DEN_W-1:0] div_divisor;
	logic [CNT_W-1:0] div_iters;
	logic             div_done;

	always_comb begin
		unique case (cmd.div_sel)
			DIV_C: begin
				div_dividend = cube_q;
				div_divisor  = (cub_q == '0) ? DEN_W'(1) : DEN_W'(cub_q);
				div_iters    = ITER_C;
			end
			DIV_L: begin
				div_dividend = {u_q, {(DIV_W-16){1'b0}}};
				div_divisor  = den_q;
				div_iters    = ITER_L;
			end
			default: begin
				div_dividend = {u_q, {(DIV_W-16){1'b0}}};
				div_divisor  = DEN_W'(n_q);
				div_iters    = ITER_Q;
			end
		endcase
	end

	rrdt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.iters    (div_iters),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Ratio update: sum of terms, correction, damping and clamp.
	logic [T1_W:0]          sum_c;
	logic [MAG_W-1:0]       mag_c;
	logic signed [RS_W-1:0] rs_c, dev_c, nom_s;
	logic [RS_W-1:0]        adev_c;
	logic                   win_c;
	logic [RATIO_W-1:0]     rc_c;

	always_comb begin
		sum_c = (T1_W+1)'(t1_q) + (T1_W+1)'(t2_q);
		if (huge_q || sum_c > (T1_W+1)'(RATIO_LIM)) begin
			mag_c = RATIO_LIM;
		end else begin
			mag_c = sum_c[MAG_W-1:0];
		end
		nom_s = $signed({{(RS_W-RATIO_W){1'b0}}, nom_q});
		if (off_q > 0) begin
			rs_c = $signed({{(RS_W-RATIO_W){1'b0}}, r_q}) -
				$signed({{(RS_W-MAG_W){1'b0}}, mag_c});
		end else begin
			rs_c = $signed({{(RS_W-RATIO_W){1'b0}}, r_q}) +
				$signed({{(RS_W-MAG_W){1'b0}}, mag_c});
		end
		dev_c  = rs_c - nom_s;
		adev_c = (dev_c < 0) ? RS_W'(-dev_c) : RS_W'(dev_c);
		win_c  = win_q;
		if (win_q) begin
			if (off_q > OFF_W'(150) || off_q < -OFF_W'(150)) begin
				win_c = 1'b0;
			end
		end else if (off_q < OFF_W'(50) && off_q > -OFF_W'(50)) begin
			if (adev_c > DAMP_EPS) begin
				rs_c = nom_s;
			end
			win_c = 1'b1;
		end
		if (rs_c < $signed({{(RS_W-RATIO_W){1'b0}}, RATIO_MIN})) begin
			rc_c = RATIO_MIN;
		end else if (rs_c > $signed({{(RS_W-RATIO_W){1'b0}}, RATIO_MAX})) begin
			rc_c = RATIO_MAX;
		end else begin
			rc_c = rs_c[RATIO_W-1:0];
		end
	end

	// Frames to request: ceiling of n times ratio, plus two.
	logic [PROD_W-1:0] prod_c;
	logic [15:0]       req_c;

	always_comb begin
		prod_c = PROD_W'(n_q) * PROD_W'(ratio_q) + ROUND_UP;
		req_c  = 16'(prod_c >> RATIO_FRAC_BITS) + 16'd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q     <= RST_NOMINAL;
			win_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fin) begin
				ratio_q <= rc_c;
				win_q   <= win_c;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= n_c;
			off_q <= off_s;
			u_q   <= (off_s < 0) ? 16'(-off_s) : 16'(off_s);
			act_q <= act_c;
			frm_q <= frm_s[15:0];
			r_q   <= (act_c == ACT_NONE) ? ratio_q : nom_q;
			den_q <= DEN_W'(n_c) * DEN_W'(lin_e);
		end
		if (cmd.div_take) begin
			unique case (cmd.div_sel)
				DIV_C: t1_q <= T1_W'(div_quo >> (40 - RATIO_FRAC_BITS));
				DIV_L: t2_q <= div_quo[T2_W-1:0];
				default: begin
					qv_q   <= div_quo[Q_W-1:0];
					huge_q <= div_quo >= (DIV_W'(256) << 20);
				end
			endcase
		end
		if (cmd.sq) begin
			sq_q <= SQ_W'((56'(qv_q) * 56'(qv_q)) >> 20);
		end
		if (cmd.mlo) begin
			cube_q <= DIV_W'(sq_q) * DIV_W'(qv_q[13:0]);
		end
		if (cmd.mhi) begin
			cube_q <= cube_q + ((DIV_W'(sq_q) * DIV_W'(qv_q[Q_W-1:14])) << 14);
		end
		if (cmd.emit) begin
			oact_q <= act_q;
			ofrm_q <= frm_q;
			orat_q <= ratio_q;
			ooff_q <= off_q[15:0];
			oreq_q <= req_c;
		end
	end

	assign stat.div_done = div_done;
	assign stat.huge     = huge_q;
	assign stat.out_full = out_valid_q && !out_ready;

	assign out_valid   = out_valid_q;
	assign out_action  = oact_q;
	assign out_frames  = ofrm_q;
	assign out_ratio   = orat_q;
	assign out_offset  = $signed(ooff_q);
	assign out_request = oreq_q;

endmodule

/* rtl/rrdt_ctrl.sv */
// Controller state machine that sequences one item through the datapath.
// Depends on rrdt_pkg for the state type and the command/status structs.
module rrdt_ctrl import rrdt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ctl_stat_t stat,
	output ctl_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_DIVQ;
			ST_DIVQ:  state_d = ST_WAITQ;
			ST_WAITQ: if (stat.div_done) state_d = ST_SQ;
			ST_SQ:    state_d = stat.huge ? ST_FIN : ST_MLO;
			ST_MLO:   state_d = ST_MHI;
			ST_MHI:   state_d = ST_DIVC;
			ST_DIVC:  state_d = ST_WAITC;
			ST_WAITC: if (stat.div_done) state_d = ST_DIVL;
			ST_DIVL:  state_d = ST_WAITL;
			ST_WAITL: if (stat.div_done) state_d = ST_FIN;
			ST_FIN:   state_d = ST_EMIT;
			ST_EMIT:  if (!stat.out_full) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIVQ: begin
				cmd.div_sel = DIV_Q;
				cmd.div_go  = 1'b1;
			end
			ST_WAITQ: begin
				cmd.div_sel  = DIV_Q;
				cmd.div_take = stat.div_done;
			end
			ST_SQ:  cmd.sq  = 1'b1;
			ST_MLO: cmd.mlo = 1'b1;
			ST_MHI: cmd.mhi = 1'b1;
			ST_DIVC: begin
				cmd.div_sel = DIV_C;
				cmd.div_go  = 1'b1;
			end
			ST_WAITC: begin
				cmd.div_sel  = DIV_C;
				cmd.div_take = stat.div_done;
			end
			ST_DIVL: begin
				cmd.div_sel = DIV_L;
				cmd.div_go  = 1'b1;
			end
			ST_WAITL: begin
				cmd.div_sel  = DIV_L;
				cmd.div_take = stat.div_done;
			end
			ST_FIN:  cmd.fin  = 1'b1;
			ST_EMIT: cmd.emit = !stat.out_full;
			default: ;
		endcase
	end

endmodule
